>>> hw/rtl/mqtl_pkg.sv
// ----------------------------------------------------------------------------
// mqtl_pkg: shared types and microcode for the multi-queue task list engine
// command codes, control word layout, step addresses and the program rom
// ----------------------------------------------------------------------------
package mqtl_pkg;

  // default sizes
  localparam int NUM_QUEUES_DEF = 8;
  localparam int MAX_TASKS_DEF  = 16;

  // stream payload widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // command codes
  typedef enum logic [1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_REMOVE     = 2'd2,
    CMD_POP        = 2'd3
  } cmd_t;

  // datapath operation of one step
  typedef enum logic [2:0] {
    OP_FETCH    = 3'd0,
    OP_HEAD     = 3'd1,
    OP_UNLINK   = 3'd2,
    OP_LINK_NEW = 3'd3,
    OP_SEAL     = 3'd4,
    OP_NOP      = 3'd5
  } op_t;

  // how a step ends
  typedef enum logic [1:0] {
    FIN_NO       = 2'd0,
    FIN_YES      = 2'd1,
    FIN_IF_EMPTY = 2'd2
  } fin_t;

  typedef struct packed {
    op_t  op;
    logic front;
    fin_t fin;
  } uword_t;

  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE     = 3'd0;
  localparam pc_t PC_POP_HEAD = 3'd1;
  localparam pc_t PC_UNLINK   = 3'd2;
  localparam pc_t PC_PB_LINK  = 3'd3;
  localparam pc_t PC_PB_SEAL  = 3'd4;
  localparam pc_t PC_PF_LINK  = 3'd5;
  localparam pc_t PC_PF_SEAL  = 3'd6;
  localparam pc_t PC_NOP      = 3'd7;

  // program rom: one control word per step
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    w = '{op: OP_NOP, front: 1'b0, fin: FIN_YES};
    unique case (pc)
      PC_IDLE:     w = '{op: OP_FETCH,    front: 1'b0, fin: FIN_NO};
      PC_POP_HEAD: w = '{op: OP_HEAD,     front: 1'b0, fin: FIN_IF_EMPTY};
      PC_UNLINK:   w = '{op: OP_UNLINK,   front: 1'b0, fin: FIN_YES};
      PC_PB_LINK:  w = '{op: OP_LINK_NEW, front: 1'b0, fin: FIN_IF_EMPTY};
      PC_PB_SEAL:  w = '{op: OP_SEAL,     front: 1'b0, fin: FIN_YES};
      PC_PF_LINK:  w = '{op: OP_LINK_NEW, front: 1'b1, fin: FIN_IF_EMPTY};
      PC_PF_SEAL:  w = '{op: OP_SEAL,     front: 1'b1, fin: FIN_YES};
      PC_NOP:      w = '{op: OP_NOP,      front: 1'b0, fin: FIN_YES};
      default:     w = '{op: OP_NOP,      front: 1'b0, fin: FIN_YES};
    endcase
    return w;
  endfunction

  // entry step for an accepted command
  function automatic pc_t dispatch(input cmd_t cmd, input logic q_ok, input logic t_ok);
    pc_t pc;
    pc = PC_NOP;
    if (!q_ok) begin
      pc = PC_NOP;
    end else if (cmd == CMD_POP) begin
      pc = PC_POP_HEAD;
    end else if (!t_ok) begin
      pc = PC_NOP;
    end else begin
      unique case (cmd)
        CMD_PUSH_BACK:  pc = PC_PB_LINK;
        CMD_PUSH_FRONT: pc = PC_PF_LINK;
        CMD_REMOVE:     pc = PC_UNLINK;
        default:        pc = PC_NOP;
      endcase
    end
    return pc;
  endfunction

endpackage

>>> hw/rtl/mqtl_link_store.sv
// ----------------------------------------------------------------------------
// mqtl_link_store: next and previous link memories of the task slots
// one registered read of both links per cycle, one write port per memory
// ----------------------------------------------------------------------------
module mqtl_link_store #(
  parameter  int MAX_TASKS = mqtl_pkg::MAX_TASKS_DEF,
  localparam int TA_W      = $clog2(MAX_TASKS),
  localparam int LINK_W    = $clog2(MAX_TASKS + 1)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [TA_W-1:0]   rd_addr,
  output logic [LINK_W-1:0] rd_next,
  output logic [LINK_W-1:0] rd_prev,
  input  logic              nxt_we,
  input  logic [TA_W-1:0]   nxt_waddr,
  input  logic [LINK_W-1:0] nxt_wdata,
  input  logic              prv_we,
  input  logic [TA_W-1:0]   prv_waddr,
  input  logic [LINK_W-1:0] prv_wdata
);

  logic [LINK_W-1:0] next_mem [MAX_TASKS];
  logic [LINK_W-1:0] prev_mem [MAX_TASKS];
  logic [LINK_W-1:0] rd_next_r;
  logic [LINK_W-1:0] rd_prev_r;

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      next_mem[nxt_waddr] <= nxt_wdata;
    end
    if (rd_en) begin
      rd_next_r <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (prv_we) begin
      prev_mem[prv_waddr] <= prv_wdata;
    end
    if (rd_en) begin
      rd_prev_r <= prev_mem[rd_addr];
    end
  end

  assign rd_next = rd_next_r;
  assign rd_prev = rd_prev_r;

endmodule

>>> hw/rtl/multi_queue_task_list_engine.sv
// ----------------------------------------------------------------------------
// multi_queue_task_list_engine: doubly linked task queues over shared slots
// microcoded sequencer driving queue head/tail and link memories
// ----------------------------------------------------------------------------
// usage
//   in_* channel takes one command item: push back, push front, remove a
//   given task, or pop the head of the selected queue
//   out_* channel returns exactly one result item per command: popped task,
//   popped flag and whether the selected queue is empty afterwards
// sequencing
//   the step counter walks a short program; push back/front on a non-empty
//   queue and pop of a non-empty queue go on from their entry step to a
//   seal or unlink step, every other command ends on its entry step; the
//   result register loads at the end of the final step and the engine is
//   ready again as it loads, so one command is in flight at a time; the
//   queue and link memories are read through registers before the writes
// reset
//   all queues empty, input held not ready while reset is asserted; link and
//   head/tail memories need no clearing pass, an empty queue's stored
//   entries are never used
// stall
//   a held result waits in the output register; the engine takes the next
//   command meanwhile and only stalls on that command's final step
// ----------------------------------------------------------------------------
module multi_queue_task_list_engine #(
  parameter int NUM_QUEUES = mqtl_pkg::NUM_QUEUES_DEF,
  parameter int MAX_TASKS  = mqtl_pkg::MAX_TASKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] command, [4:2] queue_select, [8:5] task_id, rest zero
  input  logic [mqtl_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [3:0] popped_task, [4] popped_valid, [5] queue_now_empty, rest zero
  output logic [mqtl_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  import mqtl_pkg::*;

  localparam int TA_W   = $clog2(MAX_TASKS);
  localparam int LINK_W = $clog2(MAX_TASKS + 1);
  localparam int QA_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(MAX_TASKS);

  // input item decode
  cmd_t        in_cmd;
  logic [2:0]  in_qsel;
  logic [3:0]  in_tid;
  logic [31:0] in_q_ext;
  logic [31:0] in_t_ext;
  logic [QA_W-1:0] in_qa;
  logic [TA_W-1:0] in_ta;
  logic        in_q_ok;
  logic        in_t_ok;
  logic        accept;

  assign in_cmd   = cmd_t'(in_tdata[1:0]);
  assign in_qsel  = in_tdata[4:2];
  assign in_tid   = in_tdata[8:5];
  assign in_q_ext = 32'(in_qsel);
  assign in_t_ext = 32'(in_tid);
  assign in_qa    = in_q_ext[QA_W-1:0];
  assign in_ta    = in_t_ext[TA_W-1:0];
  assign in_q_ok  = in_q_ext < 32'(NUM_QUEUES);
  assign in_t_ok  = in_t_ext < 32'(MAX_TASKS);

  // sequencer and command registers
  pc_t             pc_r;
  pc_t             pc_nxt;
  cmd_t            cmd_r;
  logic [QA_W-1:0] qa_r;
  logic [TA_W-1:0] t_r;
  logic            q_ok_r;
  logic [TA_W-1:0] popped_r;
  logic            pvalid_r;
  logic [NUM_QUEUES-1:0] nonempty_r;
  logic [NUM_QUEUES-1:0] ne_nxt;
  logic            out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  uword_t uw;
  logic   cur_ne;
  logic   finish;
  logic   advance;
  logic   empty_after;

  // no item is taken while reset is held
  assign in_tready = rst_n && (pc_r == PC_IDLE);
  assign accept    = in_tvalid && in_tready;

  // queue head/tail memory, {head, tail} per queue
  logic [2*TA_W-1:0] qmem [NUM_QUEUES];
  logic [2*TA_W-1:0] q_rd_r;
  logic [TA_W-1:0]   head_rd;
  logic [TA_W-1:0]   tail_rd;
  logic              qm_we_raw;
  logic              qm_we;
  logic [TA_W-1:0]   qm_head;
  logic [TA_W-1:0]   qm_tail;

  assign head_rd = q_rd_r[2*TA_W-1:TA_W];
  assign tail_rd = q_rd_r[TA_W-1:0];

  always_ff @(posedge clk) begin
    if (qm_we) begin
      qmem[qa_r] <= {qm_head, qm_tail};
    end
    if (accept) begin
      q_rd_r <= qmem[in_qa];
    end
  end

  // link store
  logic              lk_rd_en;
  logic [TA_W-1:0]   lk_rd_addr;
  logic [LINK_W-1:0] nx_rd;
  logic [LINK_W-1:0] pv_rd;
  logic              nxt_we_raw;
  logic              prv_we_raw;
  logic              nxt_we;
  logic              prv_we;
  logic [TA_W-1:0]   nxt_waddr;
  logic [TA_W-1:0]   prv_waddr;
  logic [LINK_W-1:0] nxt_wdata;
  logic [LINK_W-1:0] prv_wdata;

  assign lk_rd_en   = accept || (uw.op == OP_HEAD);
  assign lk_rd_addr = accept ? in_ta : head_rd;

  mqtl_link_store #(
    .MAX_TASKS (MAX_TASKS)
  ) u_links (
    .clk       (clk),
    .rd_en     (lk_rd_en),
    .rd_addr   (lk_rd_addr),
    .rd_next   (nx_rd),
    .rd_prev   (pv_rd),
    .nxt_we    (nxt_we),
    .nxt_waddr (nxt_waddr),
    .nxt_wdata (nxt_wdata),
    .prv_we    (prv_we),
    .prv_waddr (prv_waddr),
    .prv_wdata (prv_wdata)
  );

  // step decode and datapath
  logic ne_set;
  logic ne_clr;
  logic at_head;
  logic at_tail;
  logic nx_slot;
  logic pv_slot;
  logic [LINK_W-1:0] t_link;

  assign t_link  = LINK_W'(t_r);
  assign at_head = (head_rd == t_r);
  assign at_tail = (tail_rd == t_r);
  assign nx_slot = nx_rd < NO_LINK;
  assign pv_slot = pv_rd < NO_LINK;

  always_comb begin
    uw      = ucode_rom(pc_r);
    cur_ne  = q_ok_r && nonempty_r[qa_r];
    finish  = (uw.fin == FIN_YES) || ((uw.fin == FIN_IF_EMPTY) && !cur_ne);
    advance = !finish || !out_valid_r || out_tready;

    qm_we_raw  = 1'b0;
    qm_head    = head_rd;
    qm_tail    = tail_rd;
    nxt_we_raw = 1'b0;
    nxt_waddr  = t_r;
    nxt_wdata  = NO_LINK;
    prv_we_raw = 1'b0;
    prv_waddr  = t_r;
    prv_wdata  = NO_LINK;
    ne_set     = 1'b0;
    ne_clr     = 1'b0;

    case (uw.op)
      OP_UNLINK: begin
        if (cur_ne) begin
          // head side
          if (at_head) begin
            if (nx_slot) begin
              qm_we_raw = 1'b1;
              qm_head   = nx_rd[TA_W-1:0];
            end else begin
              ne_clr = 1'b1;
            end
          end
          // tail side
          if (at_tail) begin
            if (pv_slot) begin
              qm_we_raw = 1'b1;
              qm_tail   = pv_rd[TA_W-1:0];
            end else begin
              ne_clr = 1'b1;
            end
          end
          // neighbours: cut at an end, bridge in the middle
          nxt_waddr  = pv_rd[TA_W-1:0];
          nxt_wdata  = at_tail ? NO_LINK : nx_rd;
          nxt_we_raw = pv_slot && (at_tail || !at_head);
          prv_waddr  = nx_rd[TA_W-1:0];
          prv_wdata  = at_head ? NO_LINK : pv_rd;
          prv_we_raw = nx_slot && (at_head || !at_tail);
        end
      end
      OP_LINK_NEW: begin
        qm_we_raw = 1'b1;
        if (!cur_ne) begin
          // first task of the queue
          qm_head    = t_r;
          qm_tail    = t_r;
          nxt_we_raw = 1'b1;
          prv_we_raw = 1'b1;
          ne_set     = 1'b1;
        end else if (uw.front) begin
          qm_head    = t_r;
          prv_we_raw = 1'b1;
          prv_waddr  = head_rd;
          prv_wdata  = t_link;
          nxt_we_raw = 1'b1;
          nxt_wdata  = LINK_W'(head_rd);
        end else begin
          qm_tail    = t_r;
          nxt_we_raw = 1'b1;
          nxt_waddr  = tail_rd;
          nxt_wdata  = t_link;
          prv_we_raw = 1'b1;
          prv_wdata  = LINK_W'(tail_rd);
        end
      end
      OP_SEAL: begin
        // terminate the new end task
        if (uw.front) begin
          prv_we_raw = 1'b1;
        end else begin
          nxt_we_raw = 1'b1;
        end
      end
      default: begin
      end
    endcase

    ne_nxt = nonempty_r;
    if (ne_clr) begin
      ne_nxt[qa_r] = 1'b0;
    end
    if (ne_set) begin
      ne_nxt[qa_r] = 1'b1;
    end
    empty_after = !q_ok_r || !ne_nxt[qa_r];

    if (pc_r == PC_IDLE) begin
      pc_nxt = accept ? dispatch(in_cmd, in_q_ok, in_t_ok) : PC_IDLE;
    end else if (finish) begin
      pc_nxt = PC_IDLE;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  assign qm_we  = qm_we_raw && advance;
  assign nxt_we = nxt_we_raw && advance;
  assign prv_we = prv_we_raw && advance;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        pc_r       <= pc_nxt;
        nonempty_r <= ne_nxt;
        if (finish) begin
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  // command and result payload
  logic [31:0] popped_ext;
  assign popped_ext = 32'(popped_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      qa_r     <= in_qa;
      t_r      <= in_ta;
      q_ok_r   <= in_q_ok;
      popped_r <= '0;
      pvalid_r <= 1'b0;
    end else if ((uw.op == OP_HEAD) && cur_ne) begin
      // pop continues as an unlink of the head task
      t_r      <= head_rd;
      popped_r <= head_rd;
      pvalid_r <= 1'b1;
    end
    if (finish && advance) begin
      out_data_r <= {2'b00, empty_after, pvalid_r, popped_ext[3:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_IDLE) && !accept |=> (pc_r == PC_IDLE))
    else $error("sequencer left idle without a command");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r != PC_IDLE) && finish && pvalid_r |-> (cmd_r == CMD_POP))
    else $error("popped flag on a non-pop command");

  a_no_idle_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_IDLE) |-> !nxt_we && !prv_we && !qm_we)
    else $error("memory write while idle");

  a_push_marks: assert property (@(posedge clk) disable iff (!rst_n)
    finish && advance && ((uw.op == OP_LINK_NEW) || (uw.op == OP_SEAL))
    |=> nonempty_r[qa_r])
    else $error("queue not marked non-empty after push");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r != PC_IDLE) && finish && out_valid_r && !out_tready |=> (pc_r == $past(pc_r)))
    else $error("final step left while result register full");

endmodule
